@@ rtl/ttl_pkg.sv @@
// Shared types and constants for the thermistor temperature linearizer.
// Used by the divider cells, the polynomial cells and the top level.
package ttl_pkg;

  localparam int FS_BITS       = 16;
  localparam int ACC_BITS      = 32;
  localparam int X_BITS        = 31;
  localparam int TEMP_BITS     = 16;
  localparam int NUM_COEF_REGS = 6;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_ADDR_BITS-1:0] REG_FULL_SCALE = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_ZERO  = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_ONE   = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_TWO   = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_THREE = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_FOUR  = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_FIVE  = 3'd6;

  localparam logic [FS_BITS-1:0] FULL_SCALE_RESET = 16'd4095;

  localparam logic signed [ACC_BITS-1:0] COEF_RESET [NUM_COEF_REGS] = '{
    32'sd7307264, -32'sd16423322, 32'sd21993882,
    -32'sd16357786, 32'sd5962465, -32'sd822477
  };

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = 32'sh7fff_ffff;
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = 32'sh8000_0000;
  localparam logic signed [TEMP_BITS-1:0] TEMP_MAX = 16'sh7fff;
  localparam logic signed [TEMP_BITS-1:0] TEMP_MIN = 16'sh8000;

  typedef struct packed {
    logic valid;
    logic zero;
    logic sat;
  } ttl_ctl_t;

endpackage

@@ rtl/ttl_div_cell.sv @@
// One restoring division step: shifts in a numerator bit, subtracts the divisor
// when it fits and shifts the quotient bit into the numerator word.
// Depends on ttl_pkg for the control struct.
module ttl_div_cell #(
  parameter int ADC_BITS = 12,
  parameter int QW       = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  ttl_pkg::ttl_ctl_t   ctl_i,
  input  logic [ADC_BITS-1:0] dvs_i,
  input  logic [ADC_BITS-1:0] rem_i,
  input  logic [QW-1:0]       num_i,
  output ttl_pkg::ttl_ctl_t   ctl_o,
  output logic [ADC_BITS-1:0] dvs_o,
  output logic [ADC_BITS-1:0] rem_o,
  output logic [QW-1:0]       num_o
);

  ttl_pkg::ttl_ctl_t   ctl_r;
  logic [ADC_BITS-1:0] dvs_r;
  logic [ADC_BITS-1:0] rem_r;
  logic [QW-1:0]       num_r;
  logic [ADC_BITS-1:0] rem_nxt;
  logic [QW-1:0]       num_nxt;
  logic [ADC_BITS:0]   trial;
  logic [ADC_BITS:0]   diff;
  logic                fits;

  always_comb begin
    trial   = {rem_i, num_i[QW-1]};
    diff    = trial - {1'b0, dvs_i};
    fits    = trial >= {1'b0, dvs_i};
    rem_nxt = fits ? diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
    num_nxt = {num_i[QW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvs_r <= dvs_i;
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign dvs_o = dvs_r;
  assign rem_o = rem_r;
  assign num_o = num_r;

endmodule

@@ rtl/ttl_horner_cell.sv @@
// One Horner step over two registers: multiply by x, then floor, add the
// coefficient and clamp to the signed 32 bit range.
// Depends on ttl_pkg for widths, limits and the control struct.
module ttl_horner_cell #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  ttl_pkg::ttl_ctl_t                    ctl_i,
  input  logic [ttl_pkg::X_BITS-1:0]           x_i,
  input  logic signed [ttl_pkg::ACC_BITS-1:0]  acc_i,
  input  logic signed [ttl_pkg::ACC_BITS-1:0]  coef_i,
  output ttl_pkg::ttl_ctl_t                    ctl_o,
  output logic [ttl_pkg::X_BITS-1:0]           x_o,
  output logic signed [ttl_pkg::ACC_BITS-1:0]  acc_o
);

  localparam int PW = 2 * ttl_pkg::ACC_BITS;

  ttl_pkg::ttl_ctl_t                   mul_ctl_r;
  logic [ttl_pkg::X_BITS-1:0]          mul_x_r;
  logic signed [PW-1:0]                prod_r;
  logic signed [PW-1:0]                prod_nxt;
  ttl_pkg::ttl_ctl_t                   add_ctl_r;
  ttl_pkg::ttl_ctl_t                   add_ctl_nxt;
  logic [ttl_pkg::X_BITS-1:0]          add_x_r;
  logic signed [ttl_pkg::ACC_BITS-1:0] acc_r;
  logic signed [ttl_pkg::ACC_BITS-1:0] acc_nxt;
  logic signed [PW-1:0]                floored;
  logic signed [PW-1:0]                sum;

  always_comb begin
    prod_nxt = PW'(acc_i) * PW'($signed({1'b0, x_i}));
  end

  always_comb begin
    floored     = prod_r >>> FRAC_BITS;
    sum         = floored + PW'(coef_i);
    add_ctl_nxt = mul_ctl_r;
    if (sum > PW'(ttl_pkg::ACC_MAX)) begin
      acc_nxt         = ttl_pkg::ACC_MAX;
      add_ctl_nxt.sat = 1'b1;
    end else if (sum < PW'(ttl_pkg::ACC_MIN)) begin
      acc_nxt         = ttl_pkg::ACC_MIN;
      add_ctl_nxt.sat = 1'b1;
    end else begin
      acc_nxt = sum[ttl_pkg::ACC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_ctl_r <= '0;
      add_ctl_r <= '0;
    end else if (en) begin
      mul_ctl_r <= ctl_i;
      add_ctl_r <= add_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_x_r <= x_i;
      prod_r  <= prod_nxt;
      add_x_r <= mul_x_r;
      acc_r   <= acc_nxt;
    end
  end

  assign ctl_o = add_ctl_r;
  assign x_o   = add_x_r;
  assign acc_o = acc_r;

endmodule

@@ rtl/thermistor_temperature_linearizer.sv @@
// Top level of the thermistor temperature linearizer: register file, divider
// chain, polynomial chain and output skid. Depends on ttl_pkg, ttl_div_cell
// and ttl_horner_cell.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid, in_stall, in_adc_count             | sample in
//   out     | out_valid, out_stall, out_temperature,       | result out
//           | out_zero_count, out_saturated                |
//   cfg     | cfg_we, cfg_addr, cfg_wdata                  | write only
//
// One sample enters per cycle while the skid is empty. The pipeline holds one
// divider cell per quotient bit, a clamp stage, two per Horner cell and the
// output register. Reset clears all valid bits and loads the register resets.
// A stalled output holds one result in the output register and one in the
// skid; the whole chain and the input stall only while the skid is full.
module thermistor_temperature_linearizer #(
  parameter int ADC_BITS   = 12,
  parameter int FRAC_BITS  = 16,
  parameter int POLY_TERMS = 6
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ADC_BITS-1:0]                  in_adc_count,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ttl_pkg::TEMP_BITS-1:0] out_temperature,
  output logic                                 out_zero_count,
  output logic                                 out_saturated,
  input  logic                                 cfg_we,
  input  logic [ttl_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  logic [ttl_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  localparam int QW = ttl_pkg::FS_BITS + FRAC_BITS;
  localparam int HC = POLY_TERMS - 1;

  logic [ttl_pkg::FS_BITS-1:0]         full_scale_r;
  logic signed [ttl_pkg::ACC_BITS-1:0] coef_r [ttl_pkg::NUM_COEF_REGS];
  logic signed [ttl_pkg::ACC_BITS-1:0] coef_w [POLY_TERMS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= ttl_pkg::FULL_SCALE_RESET;
      coef_r       <= ttl_pkg::COEF_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        ttl_pkg::REG_FULL_SCALE: full_scale_r <= cfg_wdata[ttl_pkg::FS_BITS-1:0];
        ttl_pkg::REG_COEF_ZERO:  coef_r[0] <= $signed(cfg_wdata);
        ttl_pkg::REG_COEF_ONE:   coef_r[1] <= $signed(cfg_wdata);
        ttl_pkg::REG_COEF_TWO:   coef_r[2] <= $signed(cfg_wdata);
        ttl_pkg::REG_COEF_THREE: coef_r[3] <= $signed(cfg_wdata);
        ttl_pkg::REG_COEF_FOUR:  coef_r[4] <= $signed(cfg_wdata);
        ttl_pkg::REG_COEF_FIVE:  coef_r[5] <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < POLY_TERMS; k++) begin : g_coef
    if (k < ttl_pkg::NUM_COEF_REGS) begin : g_reg
      assign coef_w[k] = coef_r[k];
    end else begin : g_zero
      assign coef_w[k] = '0;
    end
  end

  logic en;
  logic skid_v_r;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // divider chain
  ttl_pkg::ttl_ctl_t   d_ctl [QW+1];
  logic [ADC_BITS-1:0] d_dvs [QW+1];
  logic [ADC_BITS-1:0] d_rem [QW+1];
  logic [QW-1:0]       d_num [QW+1];

  assign d_ctl[0].valid = in_valid && !in_stall;
  assign d_ctl[0].zero  = in_adc_count == '0;
  assign d_ctl[0].sat   = 1'b0;
  assign d_dvs[0]       = in_adc_count;
  assign d_rem[0]       = '0;
  assign d_num[0]       = QW'(full_scale_r) << FRAC_BITS;

  for (genvar i = 0; i < QW; i++) begin : g_div
    ttl_div_cell #(
      .ADC_BITS (ADC_BITS),
      .QW       (QW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (d_ctl[i]),
      .dvs_i (d_dvs[i]),
      .rem_i (d_rem[i]),
      .num_i (d_num[i]),
      .ctl_o (d_ctl[i+1]),
      .dvs_o (d_dvs[i+1]),
      .rem_o (d_rem[i+1]),
      .num_o (d_num[i+1])
    );
  end

  // clamp quotient - 1 to x
  ttl_pkg::ttl_ctl_t                prep_ctl_r;
  ttl_pkg::ttl_ctl_t                prep_ctl_nxt;
  logic [ttl_pkg::X_BITS-1:0]       prep_x_r;
  logic [ttl_pkg::X_BITS-1:0]       prep_x_nxt;
  logic [QW-1:0]                    q_minus;
  logic [QW+ttl_pkg::X_BITS-1:0]    q_ext;

  always_comb begin
    prep_ctl_nxt = d_ctl[QW];
    q_minus      = d_num[QW] - (QW'(1) << FRAC_BITS);
    q_ext        = (QW + ttl_pkg::X_BITS)'(q_minus);
    if (d_num[QW] < (QW'(1) << FRAC_BITS)) begin
      prep_x_nxt       = '0;
      prep_ctl_nxt.sat = 1'b1;
    end else if ((q_ext >> ttl_pkg::X_BITS) != '0) begin
      prep_x_nxt       = '1;
      prep_ctl_nxt.sat = 1'b1;
    end else begin
      prep_x_nxt = q_ext[ttl_pkg::X_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_ctl_r <= '0;
    end else if (en) begin
      prep_ctl_r <= prep_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_x_r <= prep_x_nxt;
    end
  end

  // Horner chain
  ttl_pkg::ttl_ctl_t                   h_ctl [HC+1];
  logic [ttl_pkg::X_BITS-1:0]          h_x   [HC+1];
  logic signed [ttl_pkg::ACC_BITS-1:0] h_acc [HC+1];

  assign h_ctl[0] = prep_ctl_r;
  assign h_x[0]   = prep_x_r;
  assign h_acc[0] = coef_w[POLY_TERMS-1];

  for (genvar j = 0; j < HC; j++) begin : g_horner
    ttl_horner_cell #(
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (h_ctl[j]),
      .x_i    (h_x[j]),
      .acc_i  (h_acc[j]),
      .coef_i (coef_w[POLY_TERMS-2-j]),
      .ctl_o  (h_ctl[j+1]),
      .x_o    (h_x[j+1]),
      .acc_o  (h_acc[j+1])
    );
  end

  // scale to Q8.8 and saturate
  logic signed [ttl_pkg::ACC_BITS-1:0]  t_full;
  logic signed [ttl_pkg::TEMP_BITS-1:0] res_temp;
  logic                                 res_zero;
  logic                                 res_sat;
  logic                                 pipe_fire;

  always_comb begin
    t_full   = h_acc[HC] >>> (FRAC_BITS - 8);
    res_zero = h_ctl[HC].zero;
    res_sat  = h_ctl[HC].sat;
    if (h_ctl[HC].zero) begin
      res_temp = ttl_pkg::TEMP_MAX;
      res_sat  = 1'b0;
    end else if (t_full > ttl_pkg::ACC_BITS'(ttl_pkg::TEMP_MAX)) begin
      res_temp = ttl_pkg::TEMP_MAX;
      res_sat  = 1'b1;
    end else if (t_full < ttl_pkg::ACC_BITS'(ttl_pkg::TEMP_MIN)) begin
      res_temp = ttl_pkg::TEMP_MIN;
      res_sat  = 1'b1;
    end else begin
      res_temp = t_full[ttl_pkg::TEMP_BITS-1:0];
    end
    pipe_fire = h_ctl[HC].valid && en;
  end

  // output register and skid
  logic                                 out_valid_r;
  logic                                 out_valid_nxt;
  logic signed [ttl_pkg::TEMP_BITS-1:0] out_temp_r;
  logic                                 out_zero_r;
  logic                                 out_sat_r;
  logic                                 skid_v_nxt;
  logic signed [ttl_pkg::TEMP_BITS-1:0] skid_temp_r;
  logic                                 skid_zero_r;
  logic                                 skid_sat_r;
  logic                                 out_free;

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r;
    skid_v_nxt    = skid_v_r;
    if (out_free) begin
      out_valid_nxt = skid_v_r || pipe_fire;
      skid_v_nxt    = 1'b0;
    end else if (pipe_fire) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) begin
        out_temp_r <= skid_temp_r;
        out_zero_r <= skid_zero_r;
        out_sat_r  <= skid_sat_r;
      end else if (pipe_fire) begin
        out_temp_r <= res_temp;
        out_zero_r <= res_zero;
        out_sat_r  <= res_sat;
      end
    end else if (pipe_fire) begin
      skid_temp_r <= res_temp;
      skid_zero_r <= res_zero;
      skid_sat_r  <= res_sat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_temperature = out_temp_r;
  assign out_zero_count  = out_zero_r;
  assign out_saturated   = out_sat_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_stall) |=> (out_valid_r && !skid_v_r))
    else $error("skid result not moved to the output register");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_zero_r) |-> (out_temp_r == ttl_pkg::TEMP_MAX && !out_sat_r))
    else $error("zero count result not forced to maximum");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !skid_v_r))
    else $error("output not empty after reset");

endmodule

@@ sim/ttl_reading_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the thermistor temperature linearizer: mirrors the register
// writes, predicts each reading in fixed point and compares transfers on the
// result channel. Depends on ttl_pkg.
module ttl_reading_checker #(
  parameter int ADC_BITS   = 12,
  parameter int FRAC_BITS  = 16,
  parameter int POLY_TERMS = 6
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [ADC_BITS-1:0]                  in_adc_count,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [ttl_pkg::TEMP_BITS-1:0] out_temperature,
  input  logic                                 out_zero_count,
  input  logic                                 out_saturated,
  input  logic                                 cfg_we,
  input  logic [ttl_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  logic [ttl_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
  output int                                   reading_errors,
  output int                                   outstanding
);

  localparam int MAX_TERMS = 8;

  typedef struct packed {
    logic signed [ttl_pkg::TEMP_BITS-1:0] temperature;
    logic                                 zero_count;
    logic                                 saturated;
  } reading_t;

  logic [ttl_pkg::FS_BITS-1:0]         fs_counts;
  logic signed [ttl_pkg::ACC_BITS-1:0] coefs [MAX_TERMS];
  reading_t                            pending_readings [$];

  function automatic reading_t linearize_count(input logic [ADC_BITS-1:0] count);
    reading_t r;
    longint   quot;
    longint   one;
    longint   x;
    longint   acc;
    longint   t;
    logic     sat;
    r.zero_count = 1'b0;
    if (count == '0) begin
      r.temperature = ttl_pkg::TEMP_MAX;
      r.zero_count  = 1'b1;
      r.saturated   = 1'b0;
      return r;
    end
    sat  = 1'b0;
    one  = longint'(1) << FRAC_BITS;
    quot = (longint'(fs_counts) << FRAC_BITS) / longint'(count);
    if (quot < one) begin
      x   = 0;
      sat = 1'b1;
    end else if (quot - one > longint'(ttl_pkg::ACC_MAX)) begin
      x   = longint'(ttl_pkg::ACC_MAX);
      sat = 1'b1;
    end else begin
      x = quot - one;
    end
    acc = coefs[POLY_TERMS-1];
    for (int k = POLY_TERMS - 2; k >= 0; k--) begin
      acc = ((acc * x) >>> FRAC_BITS) + coefs[k];
      if (acc > longint'(ttl_pkg::ACC_MAX)) begin
        acc = longint'(ttl_pkg::ACC_MAX);
        sat = 1'b1;
      end else if (acc < longint'(ttl_pkg::ACC_MIN)) begin
        acc = longint'(ttl_pkg::ACC_MIN);
        sat = 1'b1;
      end
    end
    t = acc >>> (FRAC_BITS - 8);
    if (t > longint'(ttl_pkg::TEMP_MAX)) begin
      t   = longint'(ttl_pkg::TEMP_MAX);
      sat = 1'b1;
    end else if (t < longint'(ttl_pkg::TEMP_MIN)) begin
      t   = longint'(ttl_pkg::TEMP_MIN);
      sat = 1'b1;
    end
    r.temperature = ttl_pkg::TEMP_BITS'(t);
    r.saturated   = sat;
    return r;
  endfunction

  task automatic log_error(input string what, input reading_t want, input reading_t got);
    reading_errors++;
    if (reading_errors <= 10) begin
      $display("%t %s: expected temp %0d zero %0b sat %0b, got temp %0d zero %0b sat %0b",
               $realtime, what, $signed(want.temperature), want.zero_count, want.saturated,
               $signed(got.temperature), got.zero_count, got.saturated);
    end
  endtask

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (!rst_n) begin
      fs_counts <= ttl_pkg::FULL_SCALE_RESET;
      for (int i = 0; i < MAX_TERMS; i++) begin
        if (i < ttl_pkg::NUM_COEF_REGS) begin
          coefs[i] <= ttl_pkg::COEF_RESET[i];
        end else begin
          coefs[i] <= '0;
        end
      end
      pending_readings.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          ttl_pkg::REG_FULL_SCALE: fs_counts <= cfg_wdata[ttl_pkg::FS_BITS-1:0];
          ttl_pkg::REG_COEF_ZERO, ttl_pkg::REG_COEF_ONE, ttl_pkg::REG_COEF_TWO,
          ttl_pkg::REG_COEF_THREE, ttl_pkg::REG_COEF_FOUR,
          ttl_pkg::REG_COEF_FIVE: coefs[cfg_addr - ttl_pkg::REG_COEF_ZERO] <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pending_readings.push_back(linearize_count(in_adc_count));
      end
      if (out_valid && !out_stall) begin
        got = '{out_temperature, out_zero_count, out_saturated};
        if (pending_readings.size() == 0) begin
          log_error("unexpected transfer", '0, got);
        end else begin
          want = pending_readings.pop_front();
          if (got.temperature !== want.temperature || got.zero_count !== want.zero_count ||
              got.saturated !== want.saturated) begin
            log_error("reading mismatch", want, got);
          end
        end
      end
      outstanding <= pending_readings.size();
    end
  end

endmodule

@@ sim/thermistor_temperature_linearizer_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the thermistor temperature linearizer: clock, reset, register
// programming, sample stimulus and result-side stalls. Depends on ttl_pkg, the
// block and ttl_reading_checker, which predicts and compares.
module thermistor_temperature_linearizer_tb;

  localparam int ADC_BITS         = 12;
  localparam int FRAC_BITS        = 16;
  localparam int POLY_TERMS       = 6;
  localparam int CLK_PERIOD       = 10;
  localparam int DRAIN_CYCLES     = 64;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS      = 200;
  localparam int TIMEOUT_CYCLES   = 400000;

  localparam logic [ttl_pkg::CFG_ADDR_BITS-1:0] REG_SPARE = 3'd7;

  localparam logic [ADC_BITS-1:0] EDGE_COUNTS [11] = '{
    12'd0, 12'd1, 12'd2, 12'd3, 12'd4095, 12'd4094, 12'd2048, 12'd2047, 12'd1365,
    12'haaa, 12'h555
  };

  typedef logic signed [ttl_pkg::ACC_BITS-1:0] coef_set_t [ttl_pkg::NUM_COEF_REGS];

  logic                                 clk = 1'b0;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_stall;
  logic [ADC_BITS-1:0]                  in_adc_count;
  logic                                 out_valid;
  logic                                 out_stall;
  logic signed [ttl_pkg::TEMP_BITS-1:0] out_temperature;
  logic                                 out_zero_count;
  logic                                 out_saturated;
  logic                                 cfg_we;
  logic [ttl_pkg::CFG_ADDR_BITS-1:0]    cfg_addr;
  logic [ttl_pkg::CFG_DATA_BITS-1:0]    cfg_wdata;
  int                                   reading_errors;
  int                                   outstanding;
  bit                                   quiet_phase = 1'b0;
  bit                                   hold_requested = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  thermistor_temperature_linearizer #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS),
    .POLY_TERMS(POLY_TERMS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_adc_count   (in_adc_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_temperature(out_temperature),
    .out_zero_count (out_zero_count),
    .out_saturated  (out_saturated),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  ttl_reading_checker #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS),
    .POLY_TERMS(POLY_TERMS)
  ) results (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_adc_count   (in_adc_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_temperature(out_temperature),
    .out_zero_count (out_zero_count),
    .out_saturated  (out_saturated),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .reading_errors (reading_errors),
    .outstanding    (outstanding)
  );

  task automatic send_count(input logic [ADC_BITS-1:0] count);
    in_valid     <= 1'b1;
    in_adc_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic program_config(input logic [ttl_pkg::FS_BITS-1:0] fs, input coef_set_t c);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= ttl_pkg::REG_FULL_SCALE;
    cfg_wdata <= ttl_pkg::CFG_DATA_BITS'(fs);
    @(posedge clk);
    for (int i = 0; i < ttl_pkg::NUM_COEF_REGS; i++) begin
      cfg_addr  <= ttl_pkg::REG_COEF_ZERO + ttl_pkg::CFG_ADDR_BITS'(i);
      cfg_wdata <= c[i];
      @(posedge clk);
    end
    cfg_addr  <= REG_SPARE;
    cfg_wdata <= $urandom();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_coefs(input bit full_range, output coef_set_t c);
    for (int i = 0; i < ttl_pkg::NUM_COEF_REGS; i++) begin
      if (full_range) begin
        c[i] = $urandom();
      end else begin
        c[i] = ttl_pkg::ACC_BITS'($urandom_range(0, 32'h1f_ffff)) - 32'sh10_0000;
      end
    end
  endtask

  task automatic run_random(input int items, input bit pressure);
    logic [ADC_BITS-1:0] count;
    for (int i = 0; i < items; i++) begin
      if (pressure && i == items / 4) hold_requested = 1'b1;
      case ($urandom_range(0, 9))
        0: count = $urandom_range(0, 1) ? '1 : '0;
        1: count = ADC_BITS'($urandom_range(1, 15));
        default: count = ADC_BITS'($urandom());
      endcase
      send_count(count);
    end
  endtask

  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requested) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall      <= 1'b0;
        hold_requested = 1'b0;
      end else if (rst_n && !quiet_phase && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    coef_set_t                   c;
    logic [ttl_pkg::FS_BITS-1:0] fs;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_adc_count <= '0;
    cfg_we       <= 1'b0;
    cfg_addr     <= ttl_pkg::REG_FULL_SCALE;
    cfg_wdata    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (EDGE_COUNTS[i]) send_count(EDGE_COUNTS[i]);

    program_config(16'd1, ttl_pkg::COEF_RESET);
    send_count(12'd1);
    send_count(12'd2);
    send_count(12'd4095);
    send_count(12'd0);

    c = '{default: ttl_pkg::ACC_MAX};
    program_config(16'hffff, c);
    send_count(12'd1);
    send_count(12'd4095);
    send_count(12'd0);

    c = '{default: ttl_pkg::ACC_MIN};
    program_config(16'hffff, c);
    send_count(12'd1);
    send_count(12'd4095);

    c    = '{default: '0};
    c[0] = ttl_pkg::ACC_MIN;
    program_config(ttl_pkg::FULL_SCALE_RESET, c);
    send_count(12'd100);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          fs = ttl_pkg::FULL_SCALE_RESET;
          c  = ttl_pkg::COEF_RESET;
        end
        1: begin
          fs = ttl_pkg::FS_BITS'($urandom_range(1, 65535));
          pick_coefs(1'b0, c);
        end
        2: begin
          fs = ttl_pkg::FS_BITS'($urandom_range(1, 65535));
          pick_coefs(1'b1, c);
        end
        3: begin
          fs = 16'd1;
          pick_coefs(1'b0, c);
        end
        4: begin
          fs = 16'hffff;
          pick_coefs(1'b1, c);
        end
        default: begin
          fs = ttl_pkg::FS_BITS'($urandom_range(2048, 8191));
          pick_coefs(1'b0, c);
        end
      endcase
      program_config(fs, c);
      if (p == 5) quiet_phase = 1'b1;
      run_random(PHASE_ITEMS, p == 0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (reading_errors == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
